// ----- sv/u8dw_pkg.sv -----
package u8dw_pkg;

	localparam int NUM_WIDE = 14;

	localparam logic [20:0] WIDE_LO [NUM_WIDE] = '{
		21'h01100, 21'h02329, 21'h02E80, 21'h03040, 21'h0AC00, 21'h0F900, 21'h0FE10,
		21'h0FE30, 21'h0FF00, 21'h0FFE0, 21'h1F300, 21'h1F900, 21'h20000, 21'h30000
	};

	localparam logic [20:0] WIDE_HI [NUM_WIDE] = '{
		21'h01160, 21'h0232B, 21'h0303F, 21'h0A4D0, 21'h0D7A4, 21'h0FB00, 21'h0FE1A,
		21'h0FE70, 21'h0FF61, 21'h0FFE7, 21'h1F650, 21'h1FA00, 21'h2FFFE, 21'h3FFFE
	};

	localparam logic [20:0] WIDTH_LIMIT = 21'h3FFFE;

	localparam logic [1:0] WIDTH_NONE   = 2'd0;
	localparam logic [1:0] WIDTH_NORMAL = 2'd1;
	localparam logic [1:0] WIDTH_WIDE   = 2'd2;

	typedef struct packed {
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic [7:0] third_byte;
		logic [7:0] fourth_byte;
		logic [2:0] bytes_available;
	} in_t;

	typedef struct packed {
		logic [20:0] scalar;
		logic [2:0]  char_length;
		logic [1:0]  fault_position;
		logic [2:0]  advance;
		logic [1:0]  display_width;
	} out_t;

	typedef struct packed {
		logic [20:0] scalar;
		logic [2:0]  char_length;
		logic [1:0]  fault_position;
	} dec_t;

endpackage

// ----- sv/u8dw_decode.sv -----
module u8dw_decode (
	input  u8dw_pkg::in_t  din,
	output u8dw_pkg::dec_t dout
);

	logic [2:0] avail;
	logic       c1;
	logic       c2;
	logic       c3;
	logic [2:0] len;
	logic [1:0] pos;

	assign avail = (din.bytes_available > 3'd4) ? 3'd4 : din.bytes_available;
	assign c1 = (din.second_byte[7:6] == 2'b10);
	assign c2 = (din.third_byte[7:6] == 2'b10);
	assign c3 = (din.fourth_byte[7:6] == 2'b10);

	always_comb begin
		len = 3'd0;
		pos = 2'd0;
		if (avail < 3'd1) begin
			len = 3'd0;
		end else if (!din.first_byte[7]) begin
			len = 3'd1;
		end else if (avail < 3'd2) begin
			len = 3'd0;
		end else if (!c1) begin
			pos = 2'd1;
		end else if (din.first_byte[7:5] == 3'b110) begin
			len = 3'd2;
		end else if (avail < 3'd3) begin
			len = 3'd0;
		end else if (!c2) begin
			pos = 2'd2;
		end else if (din.first_byte[7:4] == 4'b1110) begin
			len = 3'd3;
		end else if (avail < 3'd4) begin
			len = 3'd0;
		end else if (!c3) begin
			pos = 2'd3;
		end else if (din.first_byte[7:3] == 5'b11110) begin
			len = 3'd4;
		end
	end

	always_comb begin
		dout.char_length = len;
		dout.fault_position = pos;
		case (len)
			3'd1: dout.scalar = {13'd0, din.first_byte};
			3'd2: dout.scalar = {10'd0, din.first_byte[4:0], din.second_byte[5:0]};
			3'd3: dout.scalar = {5'd0, din.first_byte[3:0], din.second_byte[5:0],
				din.third_byte[5:0]};
			3'd4: dout.scalar = {din.first_byte[2:0], din.second_byte[5:0],
				din.third_byte[5:0], din.fourth_byte[5:0]};
			default: dout.scalar = 21'd0;
		endcase
	end

endmodule

// ----- sv/u8dw_width.sv -----
module u8dw_width (
	input  logic [20:0] scalar,
	output logic [1:0]  display_width
);

	logic [u8dw_pkg::NUM_WIDE-1:0] hit;

	always_comb begin
		for (int i = 0; i < u8dw_pkg::NUM_WIDE; i++) begin
			hit[i] = (scalar >= u8dw_pkg::WIDE_LO[i]) && (scalar < u8dw_pkg::WIDE_HI[i]);
		end
	end

	always_comb begin
		if (scalar < 21'h80) begin
			if ((scalar >= 21'h20 && scalar <= 21'h7E) ||
				(scalar >= 21'h09 && scalar <= 21'h0D)) begin
				display_width = u8dw_pkg::WIDTH_NORMAL;
			end else begin
				display_width = u8dw_pkg::WIDTH_NONE;
			end
		end else if (|hit) begin
			display_width = u8dw_pkg::WIDTH_WIDE;
		end else if (scalar >= u8dw_pkg::WIDTH_LIMIT) begin
			display_width = u8dw_pkg::WIDTH_NONE;
		end else begin
			display_width = u8dw_pkg::WIDTH_NORMAL;
		end
	end

endmodule

// ----- sv/utf8_decode_with_width_unit.sv -----
// UTF-8 first-character decoder with display width.
// Decode and width lookup sit between the input register and the result register.
// Throughput: one transaction per cycle while out_ready does not stall the result register.
// An empty input register accepts while a result waits at the output.
// Reset (arst_n low, asynchronous) clears both valid flags; payload registers are not reset.
module utf8_decode_with_width_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  u8dw_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output u8dw_pkg::out_t out_data
);

	u8dw_pkg::in_t  in_s1;
	logic           valid_s1;
	u8dw_pkg::dec_t dec;
	logic [1:0]     wid;
	u8dw_pkg::out_t res;
	u8dw_pkg::out_t res_s2;
	logic           valid_s2;
	logic           adv_s1;

	assign adv_s1 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s1;

	u8dw_decode u_decode (
		.din  (in_s1),
		.dout (dec)
	);

	u8dw_width u_width (
		.scalar        (dec.scalar),
		.display_width (wid)
	);

	always_comb begin
		res.scalar = dec.scalar;
		res.char_length = dec.char_length;
		if (dec.char_length != 3'd0) begin
			res.fault_position = 2'd0;
			res.advance = dec.char_length;
			res.display_width = wid;
		end else begin
			res.fault_position = dec.fault_position;
			res.advance = 3'd1;
			res.display_width = u8dw_pkg::WIDTH_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
		if (adv_s1 && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_data = res_s2;

	a_fault_form: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.char_length == 3'd0) |->
		(res_s2.advance == 3'd1 && res_s2.scalar == 21'd0 &&
		res_s2.display_width == u8dw_pkg::WIDTH_NONE))
		else $error("fault result malformed");

	a_ok_form: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.char_length != 3'd0) |->
		(res_s2.advance == res_s2.char_length && res_s2.fault_position == 2'd0))
		else $error("success result malformed");

	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted transaction lost in input register");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(in_s1)))
		else $error("stalled input register changed");

endmodule
